@@ rtl/cpec_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// cpec_pkg
// Shared types, constants and helpers for the circle pair collision unit.
// ---------------------------------------------------------------------------
package cpec_pkg;

  localparam int FRAC_BITS_DEF   = 8;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int NORM_BITS       = 16;
  localparam int NZ_SCALE        = 1000000;
  localparam int ROOT_BITS       = 17;
  localparam int QUOT_BITS       = 17;

  typedef struct packed {
    logic signed [23:0] ax;
    logic signed [23:0] ay;
    logic signed [23:0] bx;
    logic signed [23:0] by;
    logic signed [23:0] avx;
    logic signed [23:0] avy;
    logic signed [23:0] bvx;
    logic signed [23:0] bvy;
    logic [15:0]        ra;
    logic [15:0]        rb;
  } in_t;

  typedef struct packed {
    logic signed [23:0] ax;
    logic signed [23:0] ay;
    logic signed [23:0] bx;
    logic signed [23:0] by;
    logic signed [23:0] avx;
    logic signed [23:0] avy;
    logic signed [23:0] bvx;
    logic signed [23:0] bvy;
    logic signed [24:0] dx;
    logic signed [24:0] dy;
    logic [16:0]        rsum;
    logic [33:0]        d2;
    logic               ovl;
    logic               nz;
  } item_t;

  typedef struct packed {
    logic signed [23:0] ax;
    logic signed [23:0] ay;
    logic signed [23:0] bx;
    logic signed [23:0] by;
    logic signed [23:0] avx;
    logic signed [23:0] avy;
    logic signed [23:0] bvx;
    logic signed [23:0] bvy;
    logic               ovl;
    logic               bnc;
  } res_t;

  function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
    logic signed [23:0] r;
    if (v > 32'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -32'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/cpec_queue.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// cpec_queue
// Small register FIFO; full and empty come straight from the fill count.
// ---------------------------------------------------------------------------
module cpec_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = cpec_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wp;
  logic [AW-1:0]    rp;
  logic [CW-1:0]    cnt;
  logic             wr;
  logic             rd;

  assign full  = (cnt == CW'(DEPTH));
  assign empty = (cnt == '0);
  assign wr    = push && !full;
  assign rd    = pop && !empty;
  assign dout  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (rd) begin
        rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (wr && !rd) begin
        cnt <= cnt + 1'b1;
      end else if (rd && !wr) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wp] <= din;
    end
  end

endmodule
`default_nettype wire

@@ rtl/cpec_front.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// cpec_front
// Accepts words, forms deltas and squared distance, classifies overlap and
// the near-zero distance case.
// ---------------------------------------------------------------------------
module cpec_front #(
  parameter int FRAC_BITS = cpec_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  cpec_pkg::in_t     din,
  output logic              o_valid,
  input  logic              o_ready,
  output cpec_pkg::item_t   o_item
);

  localparam longint unsigned NZ_THR =
    ((64'd1 << (2 * FRAC_BITS)) + 64'(cpec_pkg::NZ_SCALE) - 64'd1) / 64'(cpec_pkg::NZ_SCALE);
  localparam logic signed [24:0] UNIT = 25'sd1 <<< FRAC_BITS;

  logic               en;
  logic               v1, v2, v3;
  cpec_pkg::in_t      s1, s2;
  logic signed [24:0] dx1, dy1, dx2, dy2;
  logic [16:0]        rsum1, rsum2;
  logic signed [49:0] sqx_c, sqy_c;
  logic [48:0]        sqx2, sqy2;
  logic [33:0]        rs2;
  logic [49:0]        d2_c;
  logic               nz_c;

  assign en      = !v3 || o_ready;
  assign full    = !en;
  assign o_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= push;
      v2 <= v1;
      v3 <= v2;
    end
  end

  assign sqx_c = dx1 * dx1;
  assign sqy_c = dy1 * dy1;
  assign d2_c  = 50'(sqx2) + 50'(sqy2);
  assign nz_c  = 64'(d2_c) < NZ_THR;

  always_ff @(posedge clk) begin
    if (en) begin
      s1    <= din;
      dx1   <= 25'(din.ax) - 25'(din.bx);
      dy1   <= 25'(din.ay) - 25'(din.by);
      rsum1 <= 17'(din.ra) + 17'(din.rb);

      s2    <= s1;
      dx2   <= dx1;
      dy2   <= dy1;
      rsum2 <= rsum1;
      sqx2  <= sqx_c[48:0];
      sqy2  <= sqy_c[48:0];
      rs2   <= rsum1 * rsum1;

      o_item.ax   <= s2.ax;
      o_item.ay   <= s2.ay;
      o_item.bx   <= s2.bx;
      o_item.by   <= s2.by;
      o_item.avx  <= s2.avx;
      o_item.avy  <= s2.avy;
      o_item.bvx  <= s2.bvx;
      o_item.bvy  <= s2.bvy;
      o_item.dx   <= nz_c ? UNIT : dx2;
      o_item.dy   <= nz_c ? 25'sd0 : dy2;
      o_item.rsum <= rsum2;
      o_item.d2   <= d2_c[33:0];
      o_item.ovl  <= d2_c < 50'(rs2);
      o_item.nz   <= nz_c;
    end
  end

endmodule
`default_nettype wire

@@ rtl/cpec_back.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// cpec_back
// Pipelined square root, normal division, separation and impulse exchange.
// ---------------------------------------------------------------------------
module cpec_back #(
  parameter int FRAC_BITS = cpec_pkg::FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_pop,
  input  cpec_pkg::item_t  in_item,
  output logic             res_valid,
  input  logic             res_ready,
  output cpec_pkg::res_t   res
);

  localparam int SQN  = cpec_pkg::ROOT_BITS;
  localparam int DVN  = cpec_pkg::QUOT_BITS;
  localparam int NSTG = SQN + 1 + DVN + 7;
  localparam logic [16:0] UNIT = 17'd1 << FRAC_BITS;

  typedef struct packed {
    cpec_pkg::item_t it;
    logic [34:0]     v;
    logic [34:0]     r;
  } sq_t;

  typedef struct packed {
    cpec_pkg::item_t it;
    logic [16:0]     dlen;
    logic [17:0]     den;
    logic [34:0]     rx;
    logic [34:0]     ry;
    logic [16:0]     qx;
    logic [16:0]     qy;
  } dv_t;

  logic            en;
  logic [NSTG-1:0] vld;
  sq_t             seed;
  sq_t             sq [SQN];
  dv_t             pre_c;
  dv_t             pre;
  dv_t             dv [DVN];

  cpec_pkg::item_t it1, it2, it3, it4, it5, it6;
  logic signed [17:0] nx1, ny1, pen1, nx2, ny2, nx3, ny3;
  logic signed [24:0] rvx1, rvy1;
  logic signed [35:0] px2, py2;
  logic signed [42:0] vx2, vy2;
  logic signed [19:0] sxs3, sys3, sxs_c, sys_c;
  logic signed [43:0] vn3, vneg_c;
  logic [35:0]        pmx_c, pmy_c;
  logic [18:0]        prx_c, pry_c;
  logic signed [23:0] pax4, pay4, pbx4, pby4, pax5, pay5, pbx5, pby5, pax6, pay6, pbx6, pby6;
  logic               bnc4, bnc5, bnc6;
  logic [42:0]        vmag4;
  logic [16:0]        anx4, any4;
  logic               sgx4, sgy4, sgx5, sgy5, sgx6, sgy6;
  logic [38:0]        plx5, ply5;
  logic [37:0]        phx5, phy5;
  logic [59:0]        mx_c, my_c;
  logic [27:0]        dmx6, dmy6;
  logic signed [29:0] dvx_c, dvy_c;
  logic [24:0]        magx_c, magy_c;

  assign en        = !vld[NSTG-1] || res_ready;
  assign in_pop    = en && in_valid;
  assign res_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTG-2:0], in_valid};
    end
  end

  // integer square root, one result bit per stage
  always_comb begin
    seed    = '0;
    seed.it = in_item;
    seed.v  = {1'b0, in_item.d2};
  end

  genvar k;
  for (k = 0; k < SQN; k++) begin : g_sq
    localparam logic [34:0] BIT = 35'd1 << (2 * (SQN - 1 - k));
    sq_t         src;
    sq_t         nxt;
    logic [34:0] t;
    if (k == 0) begin : g_first
      assign src = seed;
    end else begin : g_rest
      assign src = sq[k-1];
    end
    always_comb begin
      nxt = src;
      t   = src.r + BIT;
      if (src.v >= t) begin
        nxt.v = src.v - t;
        nxt.r = (src.r >> 1) + BIT;
      end else begin
        nxt.r = src.r >> 1;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq[k] <= nxt;
      end
    end
  end

  // divider setup: round(|d| * 2^16 / dlen) = (|d|*2^17 + dlen) / (2*dlen)
  assign magx_c = sq[SQN-1].it.dx[24] ? 25'(-sq[SQN-1].it.dx) : 25'(sq[SQN-1].it.dx);
  assign magy_c = sq[SQN-1].it.dy[24] ? 25'(-sq[SQN-1].it.dy) : 25'(sq[SQN-1].it.dy);

  always_comb begin
    pre_c      = '0;
    pre_c.it   = sq[SQN-1].it;
    pre_c.dlen = sq[SQN-1].it.nz ? UNIT : sq[SQN-1].r[16:0];
    pre_c.den  = {pre_c.dlen, 1'b0};
    pre_c.rx   = {1'b0, magx_c[16:0], 17'd0} + 35'(pre_c.dlen);
    pre_c.ry   = {1'b0, magy_c[16:0], 17'd0} + 35'(pre_c.dlen);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre <= pre_c;
    end
  end

  for (k = 0; k < DVN; k++) begin : g_dv
    localparam int SH = DVN - 1 - k;
    dv_t         src;
    dv_t         nxt;
    logic [34:0] dsh;
    if (k == 0) begin : g_first
      assign src = pre;
    end else begin : g_rest
      assign src = dv[k-1];
    end
    always_comb begin
      nxt = src;
      dsh = 35'(src.den) << SH;
      if (src.rx >= dsh) begin
        nxt.rx     = src.rx - dsh;
        nxt.qx[SH] = 1'b1;
      end
      if (src.ry >= dsh) begin
        nxt.ry     = src.ry - dsh;
        nxt.qy[SH] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv[k] <= nxt;
      end
    end
  end

  // separation, relative normal velocity and impulse velocity deltas
  always_comb begin
    pmx_c  = px2[35] ? 36'(-px2) : 36'(px2);
    pmy_c  = py2[35] ? 36'(-py2) : 36'(py2);
    prx_c  = 19'((pmx_c + (36'd1 << cpec_pkg::NORM_BITS)) >> (cpec_pkg::NORM_BITS + 1));
    pry_c  = 19'((pmy_c + (36'd1 << cpec_pkg::NORM_BITS)) >> (cpec_pkg::NORM_BITS + 1));
    sxs_c  = px2[35] ? -$signed({1'b0, prx_c}) : $signed({1'b0, prx_c});
    sys_c  = py2[35] ? -$signed({1'b0, pry_c}) : $signed({1'b0, pry_c});
    vneg_c = -vn3;
    mx_c   = {phx5, 22'd0} + 60'(plx5) + (60'd1 << (2 * cpec_pkg::NORM_BITS - 1));
    my_c   = {phy5, 22'd0} + 60'(ply5) + (60'd1 << (2 * cpec_pkg::NORM_BITS - 1));
    dvx_c  = sgx6 ? -$signed({2'b0, dmx6}) : $signed({2'b0, dmx6});
    dvy_c  = sgy6 ? -$signed({2'b0, dmy6}) : $signed({2'b0, dmy6});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it1  <= dv[DVN-1].it;
      nx1  <= dv[DVN-1].it.dx[24] ? -$signed({1'b0, dv[DVN-1].qx}) : $signed({1'b0, dv[DVN-1].qx});
      ny1  <= dv[DVN-1].it.dy[24] ? -$signed({1'b0, dv[DVN-1].qy}) : $signed({1'b0, dv[DVN-1].qy});
      pen1 <= $signed({1'b0, dv[DVN-1].it.rsum}) - $signed({1'b0, dv[DVN-1].dlen});
      rvx1 <= 25'(dv[DVN-1].it.avx) - 25'(dv[DVN-1].it.bvx);
      rvy1 <= 25'(dv[DVN-1].it.avy) - 25'(dv[DVN-1].it.bvy);

      it2 <= it1;
      nx2 <= nx1;
      ny2 <= ny1;
      px2 <= nx1 * pen1;
      py2 <= ny1 * pen1;
      vx2 <= rvx1 * nx1;
      vy2 <= rvy1 * ny1;

      it3  <= it2;
      nx3  <= nx2;
      ny3  <= ny2;
      sxs3 <= sxs_c;
      sys3 <= sys_c;
      vn3  <= 44'(vx2) + 44'(vy2);

      it4   <= it3;
      pax4  <= it3.ovl ? cpec_pkg::sat24(32'(it3.ax) + 32'(sxs3)) : it3.ax;
      pay4  <= it3.ovl ? cpec_pkg::sat24(32'(it3.ay) + 32'(sys3)) : it3.ay;
      pbx4  <= it3.ovl ? cpec_pkg::sat24(32'(it3.bx) - 32'(sxs3)) : it3.bx;
      pby4  <= it3.ovl ? cpec_pkg::sat24(32'(it3.by) - 32'(sys3)) : it3.by;
      bnc4  <= it3.ovl && vn3[43];
      vmag4 <= vneg_c[42:0];
      anx4  <= nx3[17] ? 17'(-nx3) : 17'(nx3);
      any4  <= ny3[17] ? 17'(-ny3) : 17'(ny3);
      sgx4  <= nx3[17];
      sgy4  <= ny3[17];

      it5  <= it4;
      pax5 <= pax4;
      pay5 <= pay4;
      pbx5 <= pbx4;
      pby5 <= pby4;
      bnc5 <= bnc4;
      sgx5 <= sgx4;
      sgy5 <= sgy4;
      plx5 <= vmag4[21:0] * anx4;
      phx5 <= vmag4[42:22] * anx4;
      ply5 <= vmag4[21:0] * any4;
      phy5 <= vmag4[42:22] * any4;

      it6  <= it5;
      pax6 <= pax5;
      pay6 <= pay5;
      pbx6 <= pbx5;
      pby6 <= pby5;
      bnc6 <= bnc5;
      sgx6 <= sgx5;
      sgy6 <= sgy5;
      dmx6 <= mx_c[59:32];
      dmy6 <= my_c[59:32];

      res.ax  <= pax6;
      res.ay  <= pay6;
      res.bx  <= pbx6;
      res.by  <= pby6;
      res.avx <= bnc6 ? cpec_pkg::sat24(32'(it6.avx) + 32'(dvx_c)) : it6.avx;
      res.avy <= bnc6 ? cpec_pkg::sat24(32'(it6.avy) + 32'(dvy_c)) : it6.avy;
      res.bvx <= bnc6 ? cpec_pkg::sat24(32'(it6.bvx) - 32'(dvx_c)) : it6.bvx;
      res.bvy <= bnc6 ? cpec_pkg::sat24(32'(it6.bvy) - 32'(dvy_c)) : it6.bvy;
      res.ovl <= it6.ovl;
      res.bnc <= bnc6;
    end
  end

endmodule
`default_nettype wire

@@ rtl/circle_pair_elastic_collision_unit.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// circle_pair_elastic_collision_unit
// Equal-mass elastic collision of two circles, one pair per word.
//
//   channel  | ports                         | handshake
//   ---------+-------------------------------+--------------------------
//   input    | a_x .. b_vy, a_radius/b_radius | push / full
//   result   | new_a_x .. new_b_vy, flags     | pop / empty
//
// One word per cycle sustained unless a full queue stalls it. The 17-step
// root and 17-step divider pipelines make up most of the path to the result.
// Synchronous reset empties both queues; no clearing pass.
// A stalled result side holds the back pipeline; the front and the middle
// queue keep taking words until full.
// ---------------------------------------------------------------------------
module circle_pair_elastic_collision_unit #(
  parameter int FRAC_BITS   = cpec_pkg::FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = cpec_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [23:0] a_x,
  input  logic signed [23:0] a_y,
  input  logic signed [23:0] b_x,
  input  logic signed [23:0] b_y,
  input  logic signed [23:0] a_vx,
  input  logic signed [23:0] a_vy,
  input  logic signed [23:0] b_vx,
  input  logic signed [23:0] b_vy,
  input  logic [15:0]        a_radius,
  input  logic [15:0]        b_radius,
  input  logic               pop,
  output logic               empty,
  output logic signed [23:0] new_a_x,
  output logic signed [23:0] new_a_y,
  output logic signed [23:0] new_b_x,
  output logic signed [23:0] new_b_y,
  output logic signed [23:0] new_a_vx,
  output logic signed [23:0] new_a_vy,
  output logic signed [23:0] new_b_vx,
  output logic signed [23:0] new_b_vy,
  output logic               overlapped,
  output logic               bounced
);

  localparam int IW = $bits(cpec_pkg::item_t);
  localparam int RW = $bits(cpec_pkg::res_t);

  cpec_pkg::in_t   din;
  cpec_pkg::item_t f_item;
  cpec_pkg::item_t m_item;
  cpec_pkg::res_t  b_res;
  cpec_pkg::res_t  o_res;
  logic            f_valid;
  logic            m_full;
  logic            m_empty;
  logic            m_pop;
  logic            b_valid;
  logic            o_full;
  logic [IW-1:0]   m_dout;
  logic [RW-1:0]   o_dout;

  assign din.ax  = a_x;
  assign din.ay  = a_y;
  assign din.bx  = b_x;
  assign din.by  = b_y;
  assign din.avx = a_vx;
  assign din.avy = a_vy;
  assign din.bvx = b_vx;
  assign din.bvy = b_vy;
  assign din.ra  = a_radius;
  assign din.rb  = b_radius;

  cpec_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .din     (din),
    .o_valid (f_valid),
    .o_ready (!m_full),
    .o_item  (f_item)
  );

  cpec_queue #(.WIDTH(IW), .DEPTH(QUEUE_DEPTH)) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (f_valid),
    .din   (f_item),
    .full  (m_full),
    .pop   (m_pop),
    .dout  (m_dout),
    .empty (m_empty)
  );

  assign m_item = m_dout;

  cpec_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (!m_empty),
    .in_pop    (m_pop),
    .in_item   (m_item),
    .res_valid (b_valid),
    .res_ready (!o_full),
    .res       (b_res)
  );

  cpec_queue #(.WIDTH(RW), .DEPTH(QUEUE_DEPTH)) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (b_valid),
    .din   (b_res),
    .full  (o_full),
    .pop   (pop),
    .dout  (o_dout),
    .empty (empty)
  );

  assign o_res      = o_dout;
  assign new_a_x    = o_res.ax;
  assign new_a_y    = o_res.ay;
  assign new_b_x    = o_res.bx;
  assign new_b_y    = o_res.by;
  assign new_a_vx   = o_res.avx;
  assign new_a_vy   = o_res.avy;
  assign new_b_vx   = o_res.bvx;
  assign new_b_vy   = o_res.bvy;
  assign overlapped = o_res.ovl;
  assign bounced    = o_res.bnc;

endmodule
`default_nettype wire

@@ rtl/cpec_checker.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// cpec_checker
// Port-level checks for the circle pair collision unit.
// ---------------------------------------------------------------------------
module cpec_checker (
  input logic               clk,
  input logic               rst,
  input logic               push,
  input logic               full,
  input logic               pop,
  input logic               empty,
  input logic signed [23:0] new_a_x,
  input logic               overlapped,
  input logic               bounced
);

  a_reset_clear : assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not cleared by reset");

  a_bnc_needs_ovl : assert property (@(posedge clk) disable iff (rst)
    !empty |-> (!bounced || overlapped))
    else $error("bounce without overlap");

  a_word_held : assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("result word lost without pop");

  a_data_held : assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> $stable(new_a_x))
    else $error("result word changed while waiting");

endmodule

bind circle_pair_elastic_collision_unit cpec_checker u_chk (.*);
`default_nettype wire
